// ----- rtl/triangle_frustum_cull_unit_defines.svh -----
// ----------------------------------------------------------------------------
// triangle_frustum_cull_unit_defines
// Assertion macros used by the top RTL file of the frustum cull unit.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FRUSTUM_CULL_UNIT_DEFINES_SVH
`define TRIANGLE_FRUSTUM_CULL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tfc assertion failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define TFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tfc assertion failed (next cycle)");

`endif

// ----- rtl/tfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfc_pkg
// Types, register indexes and the arctangent table of the frustum cull unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_YAW       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PITCH     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TAN_H     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_TAN_V     = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_KEEP_BND  = 3'd7;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic [23:0]        TAN_RESET = 24'd65536;

    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

    typedef struct packed {
        logic        [15:0] tri_id;
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v0_z;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_z;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_z;
    } t_tri_in;

    typedef struct packed {
        logic [15:0] kept_id;
        logic        on_boundary;
    } t_tri_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vert;

    typedef struct packed {
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_pitch;
        logic signed [15:0] sin_pitch;
    } t_trig;

    typedef struct packed {
        t_vert              origin;
        t_trig              trig;
        logic        [23:0] tan_h;
        logic        [23:0] tan_v;
    } t_view;

    // atan(2^-i) scaled by 2^30, truncated
    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:  r = 36'sd843314856;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043836;
            5'd3:  r = 36'sd133525158;
            5'd4:  r = 36'sd67021686;
            5'd5:  r = 36'sd33543515;
            5'd6:  r = 36'sd16775850;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194282;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048575;
            5'd11: r = 36'sd524287;
            5'd12: r = 36'sd262143;
            5'd13: r = 36'sd131071;
            5'd14: r = 36'sd65535;
            5'd15: r = 36'sd32767;
            5'd16: r = 36'sd16383;
            5'd17: r = 36'sd8191;
            5'd18: r = 36'sd4095;
            5'd19: r = 36'sd2047;
            5'd20: r = 36'sd1023;
            5'd21: r = 36'sd511;
            5'd22: r = 36'sd255;
            5'd23: r = 36'sd127;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tfc_cordic.sv -----
// ----------------------------------------------------------------------------
// tfc_cordic
// Iterative CORDIC, one rotation per cycle; holds one cosine/sine pair.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_angle,
    output logic                    o_busy,
    output logic signed [15:0]      o_cos,
    output logic signed [15:0]      o_sin
);
    import tfc_pkg::*;

    localparam int CntW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CntW-1:0] LastCnt = CntW'(STEPS - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state                  r_state;
    logic        [CntW-1:0]  r_cnt;
    logic signed [35:0]      r_a, n_a;
    logic signed [33:0]      r_x, r_y, n_x, n_y;
    logic                    r_neg;
    logic signed [15:0]      r_cos, r_sin;
    logic signed [35:0]      a_init;
    logic signed [35:0]      atan_v;
    logic signed [15:0]      q_cos, q_sin;

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v,
                                                  input logic neg);
        logic signed [34:0] s;
        logic signed [18:0] r;
        logic signed [15:0] c;
        s = 35'(v) + 35'sd32768;
        r = 19'(s >>> 16);
        if (r > 19'sd16384)
            c = ONE_Q14;
        else if (r < -19'sd16384)
            c = -ONE_Q14;
        else
            c = 16'(r);
        return neg ? -c : c;
    endfunction

    assign a_init = $signed({{3{i_angle[15]}}, i_angle, 17'b0});
    assign atan_v = atan_q30(5'(r_cnt));

    always_comb begin
        if (r_a >= 0) begin
            n_x = r_x - (r_y >>> r_cnt);
            n_y = r_y + (r_x >>> r_cnt);
            n_a = r_a - atan_v;
        end else begin
            n_x = r_x + (r_y >>> r_cnt);
            n_y = r_y - (r_x >>> r_cnt);
            n_a = r_a + atan_v;
        end
    end

    assign q_cos = to_q14(r_x, r_neg);
    assign q_sin = to_q14(r_y, r_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cos   <= ONE_Q14;
            r_sin   <= '0;
        end else if (i_start) begin
            // fold into the right half plane, negate at the end
            r_state <= S_RUN;
            r_cnt   <= '0;
            r_x     <= 34'(CORDIC_GAIN);
            r_y     <= '0;
            if (a_init > HALF_PI_Q30) begin
                r_a   <= a_init - PI_Q30;
                r_neg <= 1'b1;
            end else if (a_init < -HALF_PI_Q30) begin
                r_a   <= a_init + PI_Q30;
                r_neg <= 1'b1;
            end else begin
                r_a   <= a_init;
                r_neg <= 1'b0;
            end
        end else begin
            case (r_state)
                S_RUN: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_a <= n_a;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LastCnt)
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    r_cos   <= q_cos;
                    r_sin   <= q_sin;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

`default_nettype wire

// ----- rtl/tfc_vertex_pipe.sv -----
// ----------------------------------------------------------------------------
// tfc_vertex_pipe
// Seven-stage transform of one vertex into the view frame and frustum test.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_vertex_pipe (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire tfc_pkg::t_vert i_vert,
    input  wire tfc_pkg::t_view i_view,
    output logic                o_inside
);
    import tfc_pkg::*;

    // stage 1: offset from viewpoint
    logic signed [32:0] r_dx, r_dy, r_dz;
    // stage 2: yaw products
    logic signed [48:0] r_cdx, r_sdy, r_cdy, r_sdx;
    logic signed [32:0] r_dz2;
    // stage 3: yaw-rotated coordinates at 2^-30
    logic signed [49:0] r_x1, r_y1, r_z1;
    // stage 4: pitch products
    logic signed [65:0] r_cx, r_sz, r_sx, r_cz;
    logic signed [49:0] r_y1b;
    // stage 5: Q16.16 coordinates
    logic signed [37:0] r_x, r_z;
    logic signed [35:0] r_y;
    // stage 6: scaled bounds
    logic signed [62:0] r_px, r_pz;
    logic signed [52:0] r_ay, r_az;
    logic               r_xpos;
    // stage 7
    logic               r_inside;

    logic signed [65:0] x2, z2;
    logic signed [36:0] ay, az;

    assign x2 = r_cx - r_sz;
    assign z2 = r_sx + r_cz;
    assign ay = (r_y < 0) ? -37'(r_y) : 37'(r_y);
    assign az = (r_z < 0) ? -37'(r_z) : 37'(r_z);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= 33'(i_vert.x) - 33'(i_view.origin.x);
            r_dy  <= 33'(i_vert.y) - 33'(i_view.origin.y);
            r_dz  <= 33'(i_vert.z) - 33'(i_view.origin.z);

            r_cdx <= i_view.trig.cos_yaw * r_dx;
            r_sdy <= i_view.trig.sin_yaw * r_dy;
            r_cdy <= i_view.trig.cos_yaw * r_dy;
            r_sdx <= i_view.trig.sin_yaw * r_dx;
            r_dz2 <= r_dz;

            r_x1  <= 50'(r_cdx) + 50'(r_sdy);
            r_y1  <= 50'(r_cdy) - 50'(r_sdx);
            r_z1  <= $signed({{3{r_dz2[32]}}, r_dz2, 14'b0});

            r_cx  <= i_view.trig.cos_pitch * r_x1;
            r_sz  <= i_view.trig.sin_pitch * r_z1;
            r_sx  <= i_view.trig.sin_pitch * r_x1;
            r_cz  <= i_view.trig.cos_pitch * r_z1;
            r_y1b <= r_y1;

            r_x   <= 38'(x2 >>> 28);
            r_z   <= 38'(z2 >>> 28);
            r_y   <= 36'(r_y1b >>> 14);

            r_xpos <= (r_x > 0);
            r_px  <= r_x * $signed({1'b0, i_view.tan_h});
            r_pz  <= r_x * $signed({1'b0, i_view.tan_v});
            r_ay  <= $signed({ay, 16'b0});
            r_az  <= $signed({az, 16'b0});

            r_inside <= r_xpos && (64'(r_ay) <= 64'(r_px)) && (64'(r_az) <= 64'(r_pz));
        end
    end

    assign o_inside = r_inside;

endmodule

`default_nettype wire

// ----- rtl/triangle_frustum_cull_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_frustum_cull_unit
// Streaming view frustum cull of triangles against a configurable viewpoint.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one triangle per item: an id
// and three Q16.16 vertices. Output channel o_out_valid / i_out_stall carries
// the id of each triangle that is kept, with on_boundary set when it was kept
// only because keep_boundary is on and not all vertices are inside. Culled
// triangles produce no item.
// Throughput is one item per cycle while o_in_stall is low; from acceptance
// an item passes the 7 vertex pipeline stages, then the decision stage.
// Writing yaw or pitch starts a CORDIC run in its own unit; o_in_stall is
// held high while that run lasts, config writes still land.
// Synchronous active-low reset empties the pipeline, loads the register reset
// values and sets the cached cosines to one and sines to zero.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and o_in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_frustum_cull_unit_defines.svh"

module triangle_frustum_cull_unit #(
    parameter int ID_WIDTH     = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire tfc_pkg::t_tri_in           i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output tfc_pkg::t_tri_out               o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [tfc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [tfc_pkg::CfgDataW-1:0] i_cfg_data
);
    import tfc_pkg::*;

    localparam int Depth = 7;
    localparam logic [15:0] IdMask =
        (ID_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << ID_WIDTH) - 32'd1);

    t_view               view;
    logic signed [31:0]  r_org_x, r_org_y, r_org_z;
    logic        [23:0]  r_tan_h, r_tan_v;
    logic                r_keep;
    logic                yaw_busy, pitch_busy, busy;
    logic signed [15:0]  cy, sy, cp, sp;
    logic                en, in_acc;
    logic [Depth-1:0]    r_vld;
    logic [15:0]         r_id [Depth];
    logic [2:0]          vtx_in;
    logic                r_out_valid;
    t_tri_out            r_out;
    logic                all_in, any_in;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_tan_h <= TAN_RESET;
            r_tan_v <= TAN_RESET;
            r_keep  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ORIGIN_X: r_org_x <= $signed(i_cfg_data);
                REG_ORIGIN_Y: r_org_y <= $signed(i_cfg_data);
                REG_ORIGIN_Z: r_org_z <= $signed(i_cfg_data);
                REG_TAN_H:    r_tan_h <= i_cfg_data[23:0];
                REG_TAN_V:    r_tan_v <= i_cfg_data[23:0];
                REG_KEEP_BND: r_keep  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // separate units so back-to-back yaw and pitch writes both complete
    tfc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we && (i_cfg_index == REG_YAW)),
        .i_angle ($signed(i_cfg_data[15:0])),
        .o_busy  (yaw_busy),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    tfc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we && (i_cfg_index == REG_PITCH)),
        .i_angle ($signed(i_cfg_data[15:0])),
        .o_busy  (pitch_busy),
        .o_cos   (cp),
        .o_sin   (sp)
    );

    assign busy = yaw_busy || pitch_busy;

    assign view.origin.x      = r_org_x;
    assign view.origin.y      = r_org_y;
    assign view.origin.z      = r_org_z;
    assign view.trig.cos_yaw   = cy;
    assign view.trig.sin_yaw   = sy;
    assign view.trig.cos_pitch = cp;
    assign view.trig.sin_pitch = sp;
    assign view.tan_h         = r_tan_h;
    assign view.tan_v         = r_tan_v;

    // advance the whole pipeline unless a result waits on a stalled receiver
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en || busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    tfc_vertex_pipe u_v0 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_vert   ('{x: i_in.v0_x, y: i_in.v0_y, z: i_in.v0_z}),
        .i_view   (view),
        .o_inside (vtx_in[0])
    );

    tfc_vertex_pipe u_v1 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_vert   ('{x: i_in.v1_x, y: i_in.v1_y, z: i_in.v1_z}),
        .i_view   (view),
        .o_inside (vtx_in[1])
    );

    tfc_vertex_pipe u_v2 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_vert   ('{x: i_in.v2_x, y: i_in.v2_y, z: i_in.v2_z}),
        .i_view   (view),
        .o_inside (vtx_in[2])
    );

    // carry id and valid alongside the vertex stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_id[0] <= i_in.tri_id;
            for (int k = 1; k < Depth; k++) begin
                r_id[k] <= r_id[k-1];
            end
        end
    end

    assign all_in = &vtx_in;
    assign any_in = |vtx_in;

    // decision stage: drop culled triangles, register kept ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[Depth-1] && (all_in || (any_in && r_keep));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.kept_id     <= r_id[Depth-1] & IdMask;
            r_out.on_boundary <= !all_in;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TFC_ASSERT_NOW(a_busy_stalls, busy, o_in_stall)
    `TFC_ASSERT_NOW(a_boundary_needs_keep, o_out_valid && o_out.on_boundary, r_keep)
    `TFC_ASSERT_NEXT(a_accept_enters, in_acc, r_vld[0])

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression bench for the triangle frustum cull unit.
// ----------------------------------------------------------------------------
// An initial block programs the viewpoint, then queues directed and random
// triangles. A clocked driver feeds them with random gaps. A clocked monitor
// applies random output stalls and checks each kept item against a local
// model of the viewpoint transform and the frustum test.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import tfc_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_tri_in             in_tri = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_tri_out            out_tri;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    triangle_frustum_cull_unit #(
        .ID_WIDTH    (16),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_tri),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_tri),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Local view state, mirrors what the registers hold.
    longint org_x, org_y, org_z;
    longint tan_h, tan_v;
    bit     keep_bnd;
    longint cos_yaw, sin_yaw, cos_pitch, sin_pitch;

    t_tri_in  tri_pending[$];
    t_tri_out kept_expected[$];
    int       in_gap  = 0;
    int       out_gap = 0;
    bit       no_gaps = 1'b0;
    int       errors  = 0;
    int       cycles  = 0;

    // atan(2^-i) at 2^-30 rad
    longint atan_tbl[24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };

    function automatic longint round_q14(input longint v, input bit flip);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return flip ? -r : r;
    endfunction

    // Rotate the gain vector by the angle; fold beyond a quarter turn.
    task automatic angle_to_trig(input logic signed [15:0] ang,
                                 output longint c, output longint s);
        longint a, x, y, nx;
        bit     flip;
        a = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (a > 64'sd1686629713) begin
            a -= 64'sd3373259426;
            flip = 1'b1;
        end else if (a < -64'sd1686629713) begin
            a += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a -= atan_tbl[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a += atan_tbl[i];
            end
            x = nx;
        end
        c = round_q14(x, flip);
        s = round_q14(y, flip);
    endtask

    function automatic bit vertex_in_view(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic signed [31:0] pz);
        longint dx, dy, dz, x1, y1, z1, x2, z2, x, y, z;
        dx = longint'(px) - org_x;
        dy = longint'(py) - org_y;
        dz = longint'(pz) - org_z;
        x1 = cos_yaw * dx + sin_yaw * dy;
        y1 = cos_yaw * dy - sin_yaw * dx;
        z1 = dz * 16384;
        x2 = cos_pitch * x1 - sin_pitch * z1;
        z2 = sin_pitch * x1 + cos_pitch * z1;
        x = x2 >>> 28;
        y = y1 >>> 14;
        z = z2 >>> 28;
        if (y < 0) y = -y;
        if (z < 0) z = -z;
        if (x <= 0) return 1'b0;
        return (y * 65536 <= x * tan_h) && (z * 65536 <= x * tan_v);
    endfunction

    // Count inside vertices and queue the kept id, if any.
    task automatic predict_cull(input t_tri_in t);
        int       hits;
        t_tri_out r;
        hits = int'(vertex_in_view(t.v0_x, t.v0_y, t.v0_z))
             + int'(vertex_in_view(t.v1_x, t.v1_y, t.v1_z))
             + int'(vertex_in_view(t.v2_x, t.v2_y, t.v2_z));
        r.kept_id = t.tri_id;
        if (hits == 3) begin
            r.on_boundary = 1'b0;
            kept_expected.push_back(r);
        end else if (hits > 0 && keep_bnd) begin
            r.on_boundary = 1'b1;
            kept_expected.push_back(r);
        end
    endtask

    function automatic int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, 13);
    endfunction

    // Driver: advance on each accepted item, hold the payload while stalled.
    always @(posedge i_clk) begin
        int g;
        g = in_gap;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                predict_cull(tri_pending[0]);
                void'(tri_pending.pop_front());
                g = draw_gap();
            end
            if (g > 0) begin
                in_valid <= 1'b0;
                g--;
            end else if (tri_pending.size() > 0) begin
                in_valid <= 1'b1;
                in_tri   <= tri_pending[0];
            end else begin
                in_valid <= 1'b0;
            end
            in_gap <= g;
        end
    end

    // Monitor: random stall on the output, compare each item taken.
    always @(posedge i_clk) begin
        int g;
        g = out_gap;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (kept_expected.size() == 0) begin
                    $display("%0t: item expected none actual id %h bnd %b", $time,
                             out_tri.kept_id, out_tri.on_boundary);
                    errors++;
                end else begin
                    if (out_tri.kept_id !== kept_expected[0].kept_id) begin
                        $display("%0t: kept_id expected %h actual %h", $time,
                                 kept_expected[0].kept_id, out_tri.kept_id);
                        errors++;
                    end
                    if (out_tri.on_boundary !== kept_expected[0].on_boundary) begin
                        $display("%0t: on_boundary expected %b actual %b", $time,
                                 kept_expected[0].on_boundary, out_tri.on_boundary);
                        errors++;
                    end
                    void'(kept_expected.pop_front());
                end
                g = draw_gap();
            end
            if (g > 0) begin
                out_stall <= 1'b1;
                g--;
            end else begin
                out_stall <= 1'b0;
            end
            out_gap <= g;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("triangle_frustum_cull_unit regression: fail");
            $finish;
        end
    end

    // Write one register and mirror it in the local view state.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        logic signed [31:0] s32;
        logic signed [15:0] s16;
        s32 = data;
        s16 = data[15:0];
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X: org_x = s32;
            REG_ORIGIN_Y: org_y = s32;
            REG_ORIGIN_Z: org_z = s32;
            REG_YAW:      angle_to_trig(s16, cos_yaw, sin_yaw);
            REG_PITCH:    angle_to_trig(s16, cos_pitch, sin_pitch);
            REG_TAN_H:    tan_h = data[23:0];
            REG_TAN_V:    tan_v = data[23:0];
            REG_KEEP_BND: keep_bnd = data[0];
            default: ;
        endcase
    endtask

    task automatic write_view(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [15:0] yaw,
                              input logic [15:0] pitch, input logic [23:0] th,
                              input logic [23:0] tv, input bit kb);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_YAW, {{16{yaw[15]}}, yaw});
        write_reg(REG_PITCH, {{16{pitch[15]}}, pitch});
        write_reg(REG_TAN_H, {8'h0, th});
        write_reg(REG_TAN_V, {8'h0, tv});
        write_reg(REG_KEEP_BND, {31'h0, kb});
    endtask

    // Wait for the queue and pipeline to empty before touching registers.
    task automatic drain();
        while (tri_pending.size() > 0 || in_valid || kept_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near(input longint base, input int spread);
        longint off;
        off = longint'($urandom_range(0, 2 * spread)) - spread;
        return 32'(base + off);
    endfunction

    function automatic t_tri_in make_tri(input logic [15:0] id,
                                         input logic [31:0] ax, ay, az,
                                         input logic [31:0] bx, by, bz,
                                         input logic [31:0] cx, cy, cz);
        t_tri_in t;
        t = '{id, ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    // Mostly triangles clustered around the viewpoint; some full-range noise.
    function automatic t_tri_in random_tri();
        t_tri_in t;
        int      spread;
        spread = 1 << $urandom_range(8, 22);
        t.tri_id = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            {t.v0_x, t.v0_y, t.v0_z} = {$urandom, $urandom, $urandom};
            {t.v1_x, t.v1_y, t.v1_z} = {$urandom, $urandom, $urandom};
            {t.v2_x, t.v2_y, t.v2_z} = {$urandom, $urandom, $urandom};
        end else begin
            t.v0_x = near(org_x, spread); t.v0_y = near(org_y, spread);
            t.v0_z = near(org_z, spread);
            t.v1_x = near(org_x, spread); t.v1_y = near(org_y, spread);
            t.v1_z = near(org_z, spread);
            t.v2_x = near(org_x, spread); t.v2_y = near(org_y, spread);
            t.v2_z = near(org_z, spread);
        end
        return t;
    endfunction

    initial begin
        logic [31:0] one, ten, mx, mn;
        org_x = 0; org_y = 0; org_z = 0;
        tan_h = 65536; tan_v = 65536; keep_bnd = 1'b0;
        cos_yaw = 16384; sin_yaw = 0; cos_pitch = 16384; sin_pitch = 0;
        one = 32'h0001_0000;
        ten = 32'h000A_0000;
        mx  = 32'h7FFF_FFFF;
        mn  = 32'h8000_0000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset view: looking down +x with a 90 degree frustum.
        tri_pending.push_back(make_tri(16'h0000, ten, 0, 0, ten, one, one, ten, -one, 0));
        // on the edge: |y| equal to x
        tri_pending.push_back(make_tri(16'hFFFF, ten, ten, 0, ten, -ten, ten, one, 0, 0));
        // partly inside, dropped while keep_boundary is off
        tri_pending.push_back(make_tri(16'h1234, ten, 0, 0, one, ten, 0, ten, 0, 0));
        // behind the viewpoint and exactly at x = 0
        tri_pending.push_back(make_tri(16'h5A5A, -ten, 0, 0, 0, 0, 0, ten, 0, 0));
        tri_pending.push_back(make_tri(16'hA5A5, mx, mx, mx, mn, mn, mn, mx, 0, 0));
        tri_pending.push_back(make_tri(16'h8001, mx, 0, 0, mx, mx, mn, mx, 1, 1));
        drain();

        // Boundary keep on, zero tangents: only y = z = 0 passes.
        write_view(0, 0, 0, 16'd0, 16'd0, 24'd0, 24'd0, 1'b1);
        tri_pending.push_back(make_tri(16'h0101, ten, 0, 0, ten, 0, 0, one, 0, 0));
        tri_pending.push_back(make_tri(16'h0202, ten, 0, 0, ten, 1, 0, one, 0, 1));
        tri_pending.push_back(make_tri(16'h0303, ten, 1, 0, ten, 0, 1, mn, 0, 0));
        drain();

        // Extreme angles and origins; largest tangents.
        write_view(mx, mn, mx, 16'sd25736, -16'sd25736, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        tri_pending.push_back(make_tri(16'h0404, mn, mx, mn, 0, 0, 0, mx, mn, mx));
        tri_pending.push_back(make_tri(16'h0505, mn, mn, mn, mx, mx, mx, 0, mx, 0));
        drain();
        write_view(mn, mx, mn, -16'sd25736, 16'sd25736, 24'd65536, 24'd1, 1'b0);
        tri_pending.push_back(make_tri(16'h0606, mx, mn, mx, 0, 0, 0, mn, mx, mn));
        tri_pending.push_back(make_tri(16'h0707, mx, mx, mx, mn, mn, mn, 0, 0, 0));
        // angles right past a quarter turn
        drain();
        write_view(0, 0, 0, 16'sd12868, -16'sd12869, 24'd131072, 24'd131072, 1'b1);
        tri_pending.push_back(make_tri(16'h0808, 0, ten, 0, one, ten, 0, 0, ten, one));
        tri_pending.push_back(make_tri(16'h0909, ten, 0, ten, 0, 0, ten, -ten, 0, ten));
        drain();

        // Random phases: fresh view each time, gaps off in some phases.
        for (int ph = 0; ph < 10; ph++) begin
            no_gaps = (ph % 4 == 1);
            write_view($urandom_range(0, 1) ? $urandom : near(0, 1 << 20),
                       $urandom_range(0, 1) ? $urandom : near(0, 1 << 20),
                       $urandom_range(0, 1) ? $urandom : near(0, 1 << 20),
                       16'($urandom_range(0, 51472) - 25736),
                       16'($urandom_range(0, 51472) - 25736),
                       $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                 : 24'($urandom_range(16384, 200000)),
                       $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                 : 24'($urandom_range(16384, 200000)),
                       1'($urandom_range(0, 1)));
            for (int k = 0; k < 100; k++)
                tri_pending.push_back(random_tri());
            drain();
        end

        if (errors == 0) begin
            $display("triangle_frustum_cull_unit regression: pass");
        end else begin
            $display("triangle_frustum_cull_unit regression: fail");
        end
        $finish;
    end

endmodule
